/* src/open_addressing_hash_table_unit_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the open-addressing hash table unit
// Concurrent checks clocked on clk_i and held off while rst_ni is low.
// ----------------------------------------------------------------------------
`ifndef OPEN_ADDRESSING_HASH_TABLE_UNIT_MACROS_SVH
`define OPEN_ADDRESSING_HASH_TABLE_UNIT_MACROS_SVH

`ifndef SYNTH
`define OAHT_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
`define OAHT_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);
`else
`define OAHT_ASSERT(lbl, prop, msg)
`define OAHT_ASSERT_IMP(lbl, ante, cons, msg)
`endif

`endif

/* src/oaht_pkg.sv */
// ----------------------------------------------------------------------------
// Open-addressing hash table package
// Table geometry, operation and status codes, slot marks and item types.
// ----------------------------------------------------------------------------
`default_nettype none

package oaht_pkg;

  localparam int TABLE_SIZE  = 11;
  localparam int SLOT_W      = (TABLE_SIZE > 1) ? $clog2(TABLE_SIZE) : 1;
  localparam int CNT_W       = $clog2(TABLE_SIZE + 1);

  localparam int KEY_W       = 31;
  localparam int OP_W        = 2;
  localparam int STATUS_W    = 3;
  localparam int SLOT_PORT_W = 4;
  localparam int MARK_W      = 2;

  // The key is reduced modulo the table size a byte per cycle, MSB first.
  localparam int MOD_BITS    = 8;
  localparam int MOD_STEPS   = (KEY_W + MOD_BITS - 1) / MOD_BITS;
  localparam int KEY_PAD_W   = MOD_STEPS * MOD_BITS;
  localparam int MOD_CNT_W   = (MOD_STEPS > 1) ? $clog2(MOD_STEPS) : 1;

  localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
  localparam logic [OP_W-1:0] OP_SEARCH = 2'd1;
  localparam logic [OP_W-1:0] OP_DELETE = 2'd2;

  localparam logic [STATUS_W-1:0] STATUS_INSERTED = 3'd0;
  localparam logic [STATUS_W-1:0] STATUS_FOUND    = 3'd1;
  localparam logic [STATUS_W-1:0] STATUS_DELETED  = 3'd2;
  localparam logic [STATUS_W-1:0] STATUS_ABSENT   = 3'd3;
  localparam logic [STATUS_W-1:0] STATUS_FULL     = 3'd4;

  localparam logic [MARK_W-1:0] MARK_EMPTY = 2'd0;
  localparam logic [MARK_W-1:0] MARK_USED  = 2'd1;
  localparam logic [MARK_W-1:0] MARK_GONE  = 2'd2;

  typedef struct packed {
    logic [OP_W-1:0]  operation;
    logic [KEY_W-1:0] key;
  } oaht_req_t;

  typedef struct packed {
    logic [STATUS_W-1:0]    status;
    logic [SLOT_PORT_W-1:0] slot;
  } oaht_rsp_t;

  typedef struct packed {
    logic [MARK_W-1:0] mark;
    logic [KEY_W-1:0]  key;
  } oaht_entry_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MOD,
    ST_PROBE
  } oaht_state_e;

endpackage

`default_nettype wire

/* src/open_addressing_hash_table_unit.sv */
// ----------------------------------------------------------------------------
// Open-addressing hash table unit
// Linear-probing key table with tombstones: insert, search and delete.
// ----------------------------------------------------------------------------
// Usage:
//   An item (operation and key on req_i) is taken at a rising edge where start
//   is high and busy is low. Exactly one result per item appears on rsp_o for
//   a single cycle, flagged by done_o; it must be captured in that cycle.
//   Flow: the key is first reduced modulo the table size, one byte per
//   cycle, then slots are probed one per cycle through the table memory,
//   whose read is registered. An item probes 1 to TABLE_SIZE slots before
//   its result is delivered; an unused operation code answers on the next
//   cycle. busy drops in the cycle the result is shown, so the next item
//   can be taken then. One item is in flight at a time.
//   Reset marks every slot empty at once through per-slot valid flags; no
//   clearing pass is needed. Stored keys are undefined until written.
// ----------------------------------------------------------------------------
`default_nettype none

`include "open_addressing_hash_table_unit_macros.svh"

module open_addressing_hash_table_unit
  import oaht_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      start,
  input  oaht_req_t req_i,
  output logic      busy,
  output logic      done_o,
  output oaht_rsp_t rsp_o
);

  oaht_state_e state_q, state_d;

  logic [OP_W-1:0]      op_q, op_d;
  logic [KEY_W-1:0]     key_q, key_d;
  logic [KEY_PAD_W-1:0] key_sh_q, key_sh_d;
  logic [SLOT_W-1:0]    rem_q, rem_d;
  logic [MOD_CNT_W-1:0] mod_cnt_q, mod_cnt_d;
  logic [SLOT_W-1:0]    rem_step;
  logic [SLOT_W:0]      rem_tmp;

  logic [SLOT_W-1:0]    addr_q, addr_d;
  logic [CNT_W-1:0]     issue_cnt_q, issue_cnt_d;
  logic [CNT_W-1:0]     chk_cnt_q, chk_cnt_d;

  logic                 done_q, done_d;
  oaht_rsp_t            rsp_q, rsp_d;

  // Table memory and its read port.
  oaht_entry_t          slot_mem_q [TABLE_SIZE];
  logic [TABLE_SIZE-1:0] used_vld_q;
  logic                 rd_en;
  oaht_entry_t          rd_entry_q;
  logic                 rd_used_q;
  logic [SLOT_W-1:0]    rd_slot_q;
  logic                 chk_vld_q;
  logic                 wr_en;
  oaht_entry_t          wr_entry;

  logic [MARK_W-1:0]    entry_mark;
  logic                 is_used;
  logic                 is_empty;
  logic                 key_hit;
  logic                 last_probe;
  logic                 decide;
  logic [SLOT_W-1:0]    addr_next;

  assign busy   = (state_q != ST_IDLE);
  assign done_o = done_q;
  assign rsp_o  = rsp_q;

  // Restoring remainder over one byte of the key.
  always_comb begin
    rem_step = rem_q;
    rem_tmp  = '0;
    for (int i = 0; i < MOD_BITS; i++) begin
      rem_tmp = {rem_step, key_sh_q[KEY_PAD_W-1-i]};
      if (rem_tmp >= (SLOT_W+1)'(TABLE_SIZE)) begin
        rem_tmp = rem_tmp - (SLOT_W+1)'(TABLE_SIZE);
      end
      rem_step = rem_tmp[SLOT_W-1:0];
    end
  end

  // A slot whose valid flag is clear has never been written and reads as empty.
  assign entry_mark = rd_used_q ? rd_entry_q.mark : MARK_EMPTY;
  assign is_used    = (entry_mark == MARK_USED);
  assign is_empty   = (entry_mark == MARK_EMPTY);
  assign key_hit    = (rd_entry_q.key == key_q);
  assign last_probe = (chk_cnt_q == CNT_W'(TABLE_SIZE - 1));
  assign addr_next  = (addr_q == SLOT_W'(TABLE_SIZE - 1)) ? '0 : addr_q + 1'b1;

  always_comb begin
    state_d     = state_q;
    op_d        = op_q;
    key_d       = key_q;
    key_sh_d    = key_sh_q;
    rem_d       = rem_q;
    mod_cnt_d   = mod_cnt_q;
    addr_d      = addr_q;
    issue_cnt_d = issue_cnt_q;
    chk_cnt_d   = chk_cnt_q;
    done_d      = 1'b0;
    rsp_d       = rsp_q;
    rd_en       = 1'b0;
    wr_en       = 1'b0;
    wr_entry    = '0;
    decide      = 1'b0;

    case (state_q)
      ST_IDLE: begin
        if (start) begin
          op_d      = req_i.operation;
          key_d     = req_i.key;
          key_sh_d  = KEY_PAD_W'(req_i.key);
          rem_d     = '0;
          mod_cnt_d = '0;
          if (req_i.operation == OP_INSERT || req_i.operation == OP_SEARCH ||
              req_i.operation == OP_DELETE) begin
            state_d = ST_MOD;
          end else begin
            done_d = 1'b1;
            rsp_d  = '{status: STATUS_ABSENT, slot: '0};
          end
        end
      end

      ST_MOD: begin
        rem_d     = rem_step;
        key_sh_d  = key_sh_q << MOD_BITS;
        mod_cnt_d = mod_cnt_q + 1'b1;
        if (mod_cnt_q == MOD_CNT_W'(MOD_STEPS - 1)) begin
          state_d     = ST_PROBE;
          addr_d      = rem_step;
          issue_cnt_d = '0;
          chk_cnt_d   = '0;
        end
      end

      ST_PROBE: begin
        // Reads run one slot ahead of the check of the previous read.
        if (chk_vld_q) begin
          chk_cnt_d = chk_cnt_q + 1'b1;
          if (op_q == OP_INSERT) begin
            if (!is_used) begin
              decide   = 1'b1;
              wr_en    = 1'b1;
              wr_entry = '{mark: MARK_USED, key: key_q};
              rsp_d    = '{status: STATUS_INSERTED, slot: SLOT_PORT_W'(rd_slot_q)};
            end else if (last_probe) begin
              decide = 1'b1;
              rsp_d  = '{status: STATUS_FULL, slot: '0};
            end
          end else begin
            if (is_used && key_hit) begin
              decide = 1'b1;
              if (op_q == OP_DELETE) begin
                wr_en    = 1'b1;
                wr_entry = '{mark: MARK_GONE, key: '0};
                rsp_d    = '{status: STATUS_DELETED, slot: SLOT_PORT_W'(rd_slot_q)};
              end else begin
                rsp_d = '{status: STATUS_FOUND, slot: SLOT_PORT_W'(rd_slot_q)};
              end
            end else if (is_empty || last_probe) begin
              decide = 1'b1;
              rsp_d  = '{status: STATUS_ABSENT, slot: '0};
            end
          end
        end

        if (decide) begin
          done_d  = 1'b1;
          state_d = ST_IDLE;
        end else if (issue_cnt_q < CNT_W'(TABLE_SIZE)) begin
          rd_en       = 1'b1;
          addr_d      = addr_next;
          issue_cnt_d = issue_cnt_q + 1'b1;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      done_q      <= 1'b0;
      chk_vld_q   <= 1'b0;
      used_vld_q  <= '0;
      mod_cnt_q   <= '0;
      issue_cnt_q <= '0;
      chk_cnt_q   <= '0;
    end else begin
      state_q     <= state_d;
      done_q      <= done_d;
      chk_vld_q   <= rd_en;
      mod_cnt_q   <= mod_cnt_d;
      issue_cnt_q <= issue_cnt_d;
      chk_cnt_q   <= chk_cnt_d;
      if (wr_en) begin
        used_vld_q[rd_slot_q] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    op_q     <= op_d;
    key_q    <= key_d;
    key_sh_q <= key_sh_d;
    rem_q    <= rem_d;
    addr_q   <= addr_d;
    rsp_q    <= rsp_d;
  end

  // Synchronous table memory: one write and one registered read per cycle.
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      slot_mem_q[rd_slot_q] <= wr_entry;
    end
    if (rd_en) begin
      rd_entry_q <= slot_mem_q[addr_q];
      rd_used_q  <= used_vld_q[addr_q];
      rd_slot_q  <= addr_q;
    end
  end

  `OAHT_ASSERT_IMP(a_wr_only_on_check, wr_en, state_q == ST_PROBE && chk_vld_q, "write outside a slot check")
  `OAHT_ASSERT_IMP(a_no_read_with_write, wr_en, !rd_en, "probe read issued in the deciding cycle")
  `OAHT_ASSERT_IMP(a_done_when_idle, done_q, state_q == ST_IDLE, "result shown while still busy")
  `OAHT_ASSERT_IMP(a_probe_bound, chk_vld_q, chk_cnt_q < CNT_W'(TABLE_SIZE), "probe ran past the table size")
  `OAHT_ASSERT_IMP(a_miss_slot_zero, done_q && (rsp_q.status == STATUS_ABSENT || rsp_q.status == STATUS_FULL), rsp_q.slot == '0, "nonzero slot on a miss")

endmodule

`default_nettype wire

/* bench/open_addressing_hash_table_unit_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Open-addressing hash table unit testbench
// Drives insert, search, delete and unused-operation items through the start/busy handshake,
// keeps a shadow copy of the slot keys and marks to predict every answer,
// and compares each strobed result field by field in arrival order.
// ----------------------------------------------------------------------------

module open_addressing_hash_table_unit_tb;
  import oaht_pkg::*;

  // Operation code that the block does not implement.
  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
  localparam int TAIL_CYCLES = 20;

  logic      clk_i;
  logic      rst_ni;
  logic      start;
  oaht_req_t req_i;
  logic      busy;
  logic      done_o;
  oaht_rsp_t rsp_o;

  // Shadow of the table contents.
  logic [KEY_W-1:0]  shadow_key  [TABLE_SIZE];
  logic [MARK_W-1:0] shadow_mark [TABLE_SIZE];

  oaht_rsp_t answer_q[$];
  int        error_count = 0;
  bit        idle_on = 1'b1;

  open_addressing_hash_table_unit dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .req_i  (req_i),
    .busy   (busy),
    .done_o (done_o),
    .rsp_o  (rsp_o)
  );

  always begin
    clk_i = 1'b0;
    #10;
    clk_i = 1'b1;
    #10;
  end

  // Applies one item to the shadow table and returns the answer it must give.
  function automatic oaht_rsp_t hash_table_answer(oaht_req_t item);
    oaht_rsp_t   rsp;
    int unsigned idx;
    bit          stop;
    rsp.status = STATUS_ABSENT;
    rsp.slot   = '0;
    idx        = int'(item.key) % TABLE_SIZE;
    stop       = 1'b0;
    case (item.operation)
      OP_INSERT: begin
        rsp.status = STATUS_FULL;
        for (int n = 0; n < TABLE_SIZE && !stop; n++) begin
          if (shadow_mark[idx] != MARK_USED) begin
            shadow_key[idx]  = item.key;
            shadow_mark[idx] = MARK_USED;
            rsp.status       = STATUS_INSERTED;
            rsp.slot         = idx[SLOT_PORT_W-1:0];
            stop             = 1'b1;
          end else begin
            idx = (idx + 1 >= TABLE_SIZE) ? 0 : idx + 1;
          end
        end
      end
      OP_SEARCH, OP_DELETE: begin
        for (int n = 0; n < TABLE_SIZE && !stop; n++) begin
          if (shadow_mark[idx] == MARK_USED && shadow_key[idx] == item.key) begin
            rsp.slot = idx[SLOT_PORT_W-1:0];
            stop     = 1'b1;
            if (item.operation == OP_DELETE) begin
              shadow_mark[idx] = MARK_GONE;
              shadow_key[idx]  = '0;
              rsp.status       = STATUS_DELETED;
            end else begin
              rsp.status = STATUS_FOUND;
            end
          end else if (shadow_mark[idx] == MARK_EMPTY) begin
            stop = 1'b1;
          end else begin
            idx = (idx + 1 >= TABLE_SIZE) ? 0 : idx + 1;
          end
        end
      end
      default: ;
    endcase
    return rsp;
  endfunction

  function automatic int used_slots();
    int cnt;
    cnt = 0;
    for (int i = 0; i < TABLE_SIZE; i++) begin
      if (shadow_mark[i] == MARK_USED) cnt++;
    end
    return cnt;
  endfunction

  // Called just after a rising edge; returns just after the edge that took the item,
  // with start still high so the next item can follow back to back.
  task automatic send_item(logic [OP_W-1:0] op, logic [KEY_W-1:0] key);
    oaht_req_t item;
    item.operation = op;
    item.key       = key;
    if (idle_on && $urandom_range(0, 3) == 0) begin
      start <= 1'b0;
      if ($urandom_range(0, 1) == 1) begin
        @(posedge clk_i);
        while (busy) @(posedge clk_i);
      end
      repeat ($urandom_range(1, 5)) @(posedge clk_i);
    end
    start <= 1'b1;
    req_i <= item;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    answer_q.push_back(hash_table_answer(item));
  endtask

  task automatic drain();
    start <= 1'b0;
    @(posedge clk_i);
    while (answer_q.size() != 0) @(posedge clk_i);
    repeat (TAIL_CYCLES) @(posedge clk_i);
  endtask

  task automatic test_empty_table();
    send_item(OP_SEARCH, 31'd0);
    send_item(OP_DELETE, 31'd5);
    send_item(OP_UNUSED, {KEY_W{1'b1}});
    send_item(OP_SEARCH, {KEY_W{1'b1}});
    drain();
  endtask

  // Collisions on slot 0, a duplicate insert, and probes passing tombstones.
  task automatic test_collisions_and_tombstones();
    send_item(OP_INSERT, 31'd0);
    send_item(OP_INSERT, {KEY_W{1'b1}});
    send_item(OP_INSERT, 31'd11);
    send_item(OP_INSERT, 31'd0);
    send_item(OP_SEARCH, 31'd11);
    send_item(OP_DELETE, 31'd0);
    send_item(OP_SEARCH, 31'd11);
    send_item(OP_SEARCH, 31'd0);
    send_item(OP_DELETE, 31'd0);
    send_item(OP_SEARCH, 31'd0);
    send_item(OP_INSERT, 31'd22);
    drain();
  endtask

  // Fills every free slot, then asks for one more insert and misses on a full probe.
  task automatic test_full_table();
    for (int i = 0; i < 8; i++) send_item(OP_INSERT, 31'(33 + 11 * i));
    send_item(OP_INSERT, 31'd1);
    send_item(OP_SEARCH, 31'd12);
    send_item(OP_DELETE, 31'd12);
    drain();
  endtask

  // Mostly keys from a small pool that shares a few residues, so items hit,
  // collide and wrap; the fill level is steered toward a moving target.
  task automatic test_random_traffic(int count);
    logic [KEY_W-1:0] key_pool [16];
    logic [KEY_W-1:0] key;
    logic [OP_W-1:0]  op;
    int               fill_target;
    int               r;
    fill_target = 0;
    for (int i = 0; i < 16; i++) begin
      if (i % 2 == 0) key_pool[i] = 31'(($urandom % 195225785) * 11 + $urandom_range(0, 3));
      else key_pool[i] = 31'($urandom_range(0, 63));
    end
    for (int i = 0; i < count; i++) begin
      if (i % 64 == 0) fill_target = $urandom_range(0, TABLE_SIZE);
      if ($urandom_range(0, 4) == 0) key = 31'($urandom);
      else key = key_pool[$urandom_range(0, 15)];
      r = $urandom_range(0, 99);
      if (r < 4) op = OP_UNUSED;
      else if (r < 40) op = OP_SEARCH;
      else if (r < 52) op = ($urandom_range(0, 1) == 1) ? OP_INSERT : OP_DELETE;
      else op = (used_slots() < fill_target) ? OP_INSERT : OP_DELETE;
      send_item(op, key);
    end
    drain();
  endtask

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (done_o === 1'b1) begin
        if (answer_q.size() == 0) begin
          $error("result with no item outstanding: status %0d slot %0d",
                 rsp_o.status, rsp_o.slot);
          error_count++;
        end else begin
          oaht_rsp_t exp_rsp;
          exp_rsp = answer_q.pop_front();
          if (rsp_o.status !== exp_rsp.status) begin
            $error("status: expected %0d, actual %0d", exp_rsp.status, rsp_o.status);
            error_count++;
          end
          if (rsp_o.slot !== exp_rsp.slot) begin
            $error("slot: expected %0d, actual %0d", exp_rsp.slot, rsp_o.slot);
            error_count++;
          end
        end
      end else if (done_o !== 1'b0) begin
        $error("done_o: expected 0 or 1, actual %b", done_o);
        error_count++;
      end
    end
  end

  initial begin
    for (int i = 0; i < TABLE_SIZE; i++) begin
      shadow_key[i]  = '0;
      shadow_mark[i] = MARK_EMPTY;
    end
    rst_ni = 1'b0;
    start  = 1'b0;
    req_i  = '0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_empty_table();
    test_collisions_and_tombstones();
    test_full_table();
    test_random_traffic(1000);
    idle_on = 1'b0;
    test_random_traffic(500);

    if (error_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  initial begin
    #10_000_000;
    $display("CHECK FAILED");
    $finish;
  end

endmodule

/* filelist.f */
+incdir+src
src/oaht_pkg.sv
src/open_addressing_hash_table_unit.sv
bench/open_addressing_hash_table_unit_tb.sv
